// ----- hw/rtl/rrsc_pkg.sv -----
package rrsc_pkg;

  localparam int ROTOR_SLOTS_DEF = 8;
  localparam int SQRT_STEPS_DEF = 10;

  // Quotient bits resolved per divider pipeline stage.
  localparam int DIV_BITS = 4;

  localparam logic [15:0] ROOT_START = 16'd1000;

  localparam logic [1:0] CMD_LOAD = 2'd0;
  localparam logic [1:0] CMD_F2S = 2'd1;
  localparam logic [1:0] CMD_S2F = 2'd2;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0]  command;
    logic [2:0]  rotor_index;
    logic [15:0] value;
    logic [15:0] load_max_speed;
    logic [15:0] load_max_force;
  } req_t;

  typedef struct packed {
    logic [15:0] converted;
    logic        zero_divisor;
  } rsp_t;

  // Sideband that travels with an item through the Newton root chain.
  typedef struct packed {
    logic        is_root;
    logic        byp;
    logic        flag;
    logic [15:0] res;
    logic [15:0] r;
    logic [15:0] smax;
    logic [31:0] q;
  } root_side_t;

  function automatic logic [15:0] dflt_speed(input int idx);
    logic [15:0] v;
    case (idx)
      1: v = 16'd16000;
      2: v = 16'd16000;
      3: v = 16'd14000;
      4: v = 16'd14000;
      5: v = 16'd12000;
      6: v = 16'd6000;
      default: v = 16'd0;
    endcase
    return v;
  endfunction

  function automatic logic [15:0] dflt_force(input int idx);
    logic [15:0] v;
    case (idx)
      1: v = 16'd14882;
      2: v = 16'd18603;
      3: v = 16'd14243;
      4: v = 16'd14681;
      5: v = 16'd14006;
      6: v = 16'd3200;
      default: v = 16'd0;
    endcase
    return v;
  endfunction

endpackage

// ----- hw/rtl/rrsc_div.sv -----
// Pipelined 32 by 16 bit unsigned restoring divider. A zero divisor gives 0.
module rrsc_div #(
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic [31:0]       num,
  input  logic [15:0]       den,
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_valid,
  output logic [31:0]       quot,
  output logic [SIDE_W-1:0] out_side
);

  localparam int STAGES = 32 / rrsc_pkg::DIV_BITS;

  function automatic logic [47:0] div_step(input logic [15:0] rem_i, input logic [31:0] nq_i,
                                           input logic [15:0] den_i);
    logic [16:0] r17;
    logic [15:0] rem;
    logic [31:0] nq;
    logic        ge;
    rem = rem_i;
    nq = nq_i;
    for (int i = 0; i < rrsc_pkg::DIV_BITS; i++) begin
      r17 = {rem, nq[31]};
      ge = (r17 >= {1'b0, den_i});
      rem = ge ? 16'(r17 - {1'b0, den_i}) : r17[15:0];
      nq = {nq[30:0], ge};
    end
    return {rem, nq};
  endfunction

  logic [STAGES-1:0] v;
  logic [15:0]       rem [STAGES];
  logic [31:0]       nq  [STAGES];
  logic [15:0]       dn  [STAGES];
  logic              dz  [STAGES];
  logic [SIDE_W-1:0] sd  [STAGES];
  logic [47:0]       stp [STAGES];

  always_comb begin
    stp[0] = div_step(16'd0, num, den);
    for (int s = 1; s < STAGES; s++) begin
      stp[s] = div_step(rem[s-1], nq[s-1], dn[s-1]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[STAGES-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= stp[0][47:32];
      nq[0] <= stp[0][31:0];
      dn[0] <= den;
      dz[0] <= (den == 16'd0);
      sd[0] <= in_side;
      for (int s = 1; s < STAGES; s++) begin
        rem[s] <= stp[s][47:32];
        nq[s] <= stp[s][31:0];
        dn[s] <= dn[s-1];
        dz[s] <= dz[s-1];
        sd[s] <= sd[s-1];
      end
    end
  end

  assign out_valid = v[STAGES-1];
  assign quot = dz[STAGES-1] ? 32'd0 : nq[STAGES-1];
  assign out_side = sd[STAGES-1];

endmodule

// ----- hw/rtl/rotor_rcf_speed_converter.sv -----
// Rotor speed / relative centrifugal force converter.
// Each rotor slot holds a maximum speed and a maximum force. A request item
// either loads both maxima of one slot, converts a force into a speed (square
// root by a fixed number of Newton steps), or converts a speed into a force.
// Every request item yields exactly one response item, in request order.
// Both channels use valid and stall: an item moves at a clock edge where
// valid is high and stall is low.
// The table is read and written when the request is taken, so a load is
// seen by the very next request. The work then runs through a fully
// pipelined datapath: entry, first multiply, an 8-stage divider, second
// multiply, and SQRT_STEPS rounds of an 8-stage divider plus an update
// stage. One item is taken every cycle while req_stall is low.
// A two-entry output (response register plus skid register) parts the
// sides: requests keep flowing while a response waits, and the pipeline
// freezes, with req_stall high, only once the skid register is occupied.
// Synchronous reset empties the pipeline and restores the default rotor
// table; it does not clear datapath payload.
module rotor_rcf_speed_converter #(
  parameter int ROTOR_SLOTS = rrsc_pkg::ROTOR_SLOTS_DEF,
  parameter int SQRT_STEPS = rrsc_pkg::SQRT_STEPS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  rrsc_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output rrsc_pkg::rsp_t rsp
);

  localparam int SLOT_W = $clog2(ROTOR_SLOTS);
  localparam int SIDE_W = $bits(rrsc_pkg::root_side_t);

  typedef struct packed {
    logic        is_root;
    logic        byp;
    logic        flag;
    logic [15:0] res;
    logic [15:0] smax;
    logic [15:0] fmax;
    logic [15:0] val;
  } front_t;

  typedef struct packed {
    logic        is_root;
    logic        byp;
    logic        flag;
    logic [15:0] res;
    logic [15:0] smax;
    logic [15:0] m2;
  } mid_t;

  // The whole pipeline advances together unless the skid register is full.
  logic en;
  logic accept;
  logic skid_valid;

  assign en = !skid_valid;
  assign req_stall = skid_valid;
  assign accept = req_valid && en;

  // Rotor table, read and written at the entry.
  logic [15:0] spd_tab [ROTOR_SLOTS];
  logic [15:0] frc_tab [ROTOR_SLOTS];
  logic [SLOT_W-1:0] slot;
  logic slot_ok;
  logic [15:0] smax_rd;
  logic [15:0] fmax_rd;

  assign slot = SLOT_W'(req.rotor_index);
  assign slot_ok = 32'(req.rotor_index) < ROTOR_SLOTS;
  assign smax_rd = slot_ok ? spd_tab[slot] : 16'd0;
  assign fmax_rd = slot_ok ? frc_tab[slot] : 16'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < ROTOR_SLOTS; i++) begin
        spd_tab[i] <= rrsc_pkg::dflt_speed(i);
        frc_tab[i] <= rrsc_pkg::dflt_force(i);
      end
    end else if (accept && req.command == rrsc_pkg::CMD_LOAD && slot_ok) begin
      spd_tab[slot] <= req.load_max_speed;
      frc_tab[slot] <= req.load_max_force;
    end
  end

  // Entry stage: settle the special cases that need no arithmetic.
  front_t front_next;
  front_t front;
  logic   front_v;

  always_comb begin
    front_next.is_root = (req.command == rrsc_pkg::CMD_F2S);
    front_next.byp = 1'b1;
    front_next.flag = 1'b0;
    front_next.res = 16'd0;
    front_next.smax = smax_rd;
    front_next.fmax = fmax_rd;
    front_next.val = req.value;
    case (req.command)
      rrsc_pkg::CMD_F2S: begin
        if (req.value == fmax_rd) begin
          front_next.res = smax_rd;
        end else if (fmax_rd == 16'd0) begin
          front_next.flag = 1'b1;
        end else begin
          front_next.byp = 1'b0;
        end
      end
      rrsc_pkg::CMD_S2F: begin
        if (req.value == smax_rd) begin
          front_next.res = fmax_rd;
        end else if (smax_rd == 16'd0) begin
          front_next.flag = 1'b1;
        end else begin
          front_next.byp = 1'b0;
        end
      end
      default: begin
        front_next.byp = 1'b1;
      end
    endcase
  end

  // First multiply: value times the maximum that is not the divisor.
  logic [31:0] prod1;
  logic [15:0] den1;
  mid_t        mid;
  logic        mul1_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      front_v <= 1'b0;
      mul1_v <= 1'b0;
    end else if (en) begin
      front_v <= accept;
      mul1_v <= front_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      front <= front_next;
      prod1 <= {16'd0, front.val} *
               (front.is_root ? {16'd0, front.smax} : {16'd0, front.fmax});
      den1 <= front.is_root ? front.fmax : front.smax;
      mid.is_root <= front.is_root;
      mid.byp <= front.byp;
      mid.flag <= front.flag;
      mid.res <= front.res;
      mid.smax <= front.smax;
      mid.m2 <= front.is_root ? front.smax : front.val;
    end
  end

  logic        div1_v;
  logic [31:0] quot1;
  logic [$bits(mid_t)-1:0] div1_side;
  mid_t        div1_mid;

  rrsc_div #(
    .SIDE_W($bits(mid_t))
  ) u_div1 (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (mul1_v),
    .num      (prod1),
    .den      (den1),
    .in_side  (mid),
    .out_valid(div1_v),
    .quot     (quot1),
    .out_side (div1_side)
  );

  assign div1_mid = div1_side;

  // Second multiply, wrapping to 32 bits; seeds the root estimate.
  rrsc_pkg::root_side_t rt0;
  logic                 rt0_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      rt0_v <= 1'b0;
    end else if (en) begin
      rt0_v <= div1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rt0.is_root <= div1_mid.is_root;
      rt0.byp <= div1_mid.byp;
      rt0.flag <= div1_mid.flag;
      rt0.res <= div1_mid.res;
      rt0.r <= rrsc_pkg::ROOT_START;
      rt0.smax <= div1_mid.smax;
      rt0.q <= quot1 * {16'd0, div1_mid.m2};
    end
  end

  // Root chain. For a speed to force conversion the first round divides by
  // the maximum speed and finishes the item; later rounds carry it along.
  logic [SQRT_STEPS-1:0]  dv;
  logic [31:0]            dq   [SQRT_STEPS];
  logic [SIDE_W-1:0]      dsd  [SQRT_STEPS];
  logic [SQRT_STEPS-1:0]  gl_v;
  rrsc_pkg::root_side_t   gl   [SQRT_STEPS];
  rrsc_pkg::root_side_t   gl_next [SQRT_STEPS];

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_root
    rrsc_pkg::root_side_t src;
    logic                 src_v;
    if (k == 0) begin : g_first
      assign src = rt0;
      assign src_v = rt0_v;
    end else begin : g_next
      assign src = gl[k-1];
      assign src_v = gl_v[k-1];
    end

    rrsc_div #(
      .SIDE_W(SIDE_W)
    ) u_div (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .in_valid (src_v),
      .num      (src.q),
      .den      (src.is_root ? src.r : src.smax),
      .in_side  (src),
      .out_valid(dv[k]),
      .quot     (dq[k]),
      .out_side (dsd[k])
    );
  end

  always_comb begin
    for (int k = 0; k < SQRT_STEPS; k++) begin
      logic [17:0] sum;
      gl_next[k] = dsd[k];
      sum = {2'b00, gl_next[k].r} + {1'b0, dq[k][16:0]};
      if (gl_next[k].is_root) begin
        gl_next[k].r = sum[16:1];
      end else if (!gl_next[k].byp) begin
        gl_next[k].byp = 1'b1;
        gl_next[k].res = dq[k][15:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gl_v <= '0;
    end else if (en) begin
      gl_v <= dv;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < SQRT_STEPS; k++) begin
        gl[k] <= gl_next[k];
      end
    end
  end

  // Output register plus skid register.
  rrsc_pkg::root_side_t last;
  rrsc_pkg::rsp_t       fin;
  rrsc_pkg::rsp_t       skid;
  logic                 arrive;
  logic                 take;

  assign last = gl[SQRT_STEPS-1];
  assign fin.converted = last.byp ? last.res : last.r;
  assign fin.zero_divisor = last.flag;
  assign arrive = en && gl_v[SQRT_STEPS-1];
  assign take = rsp_valid && !rsp_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (take) begin
        rsp <= skid;
        skid_valid <= 1'b0;
      end
    end else if (arrive) begin
      if (!rsp_valid || take) begin
        rsp <= fin;
        rsp_valid <= 1'b1;
      end else begin
        skid <= fin;
        skid_valid <= 1'b1;
      end
    end else if (take) begin
      rsp_valid <= 1'b0;
    end
  end

endmodule
